// ----- src/buddy_free_block_coalescer_assert.svh -----
// Assertion macros shared by the checker.
`ifndef BUDDY_FREE_BLOCK_COALESCER_ASSERT_SVH
`define BUDDY_FREE_BLOCK_COALESCER_ASSERT_SVH

// Same-cycle implication.
`define BFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bfc_pkg.sv -----
package bfc_pkg;

   localparam int ADDR_BITS_DEFAULT = 10;

   localparam int FUNC_W   = 1;
   localparam int ORDER_W  = 4;
   localparam int ADDR_W   = 10;
   localparam int STATUS_W = 2;

   // widest bitmap row: 32 block bits per row
   localparam int MAX_COL_W = 5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_FETCH  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_LISTED = 2'd0,
      ST_END    = 2'd1,
      ST_ACCEPT = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_OVL_RD,
      S_OVL_TEST,
      S_OCC,
      S_MRG_RD,
      S_MRG_TEST,
      S_SET,
      S_SCAN,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_CUR,
      RD_BUDDY,
      RD_SCAN_FIRST,
      RD_SCAN_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_OCC_SET,
      WR_BUDDY_CLR,
      WR_FREE_SET
   } wr_sel_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_REJECT,
      RES_ACCEPT,
      RES_LISTED,
      RES_END
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        cursor_clear;
      logic        ord_load;
      logic        ord_inc;
      logic        ord_dec;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic is_fetch;
      logic bad;
      logic at_top;
      logic at_k;
      logic cur_occ;
      logic cur_free;
      logic buddy_free;
      logic hit;
      logic row_last;
      logic clr_last;
      logic out_free;
   } sts_type;

endpackage

// ----- src/bfc_req_if.sv -----
interface bfc_req_if import bfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [ORDER_W-1:0] block_order;
   logic [ADDR_W-1:0]  block_addr;

   modport source (output valid, output func, output block_order, output block_addr,
                   input ready);
   modport sink (input valid, input func, input block_order, input block_addr,
                 output ready);
endinterface

// ----- src/bfc_rsp_if.sv -----
interface bfc_rsp_if import bfc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ORDER_W-1:0]  out_order;
   logic [ADDR_W-1:0]   out_addr;
   logic                first_of_order;

   modport source (output valid, output status, output out_order, output out_addr,
                   output first_of_order, input ready);
   modport sink (input valid, input status, input out_order, input out_addr,
                 input first_of_order, output ready);
endinterface

// ----- src/buddy_free_block_coalescer.sv -----
// Buddy allocator free-list keeper. Items arrive on req_ch (valid/ready); func 0 hands
// back a freed block (block_order, block_addr), func 1 asks for the next free block.
// Each item yields exactly one item on rsp_ch: listed block, list end, insert
// accepted (with the coalesced order and address) or insert rejected.
// The block works on one item at a time; all bitmap traffic goes through one
// row-wide memory with one read and one write port.
// Insert: the overlap check reads one row per order from block_order up to the top,
// then the path down is marked occupied, free buddies are merged order by order
// (up to the top order) and the free bit is set; an overlap is rejected as soon as
// it is found, and a malformed block is rejected at decode. Fetch: rows are scanned
// from the cursor row to the last one. Rows are 32 block bits wide.
// Reset (synchronous) empties the bitmap by a clearing pass over every row,
// with req_ch.ready low throughout; the list cursor returns to the start.
// A finished result waits in an output register; while rsp_ch stalls, the next
// item is still accepted, and its result holds until the register is taken.
module buddy_free_block_coalescer import bfc_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bfc_req_if.sink   req_ch,
   bfc_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   sts_type    sts;
   logic       req_ready;
   status_type rsp_status;

   bfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfc_datapath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_ch.func),
      .req_block_order    (req_ch.block_order),
      .req_block_addr     (req_ch.block_addr),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_status         (rsp_status),
      .rsp_out_order      (rsp_ch.out_order),
      .rsp_out_addr       (rsp_ch.out_addr),
      .rsp_first_of_order (rsp_ch.first_of_order)
   );

   assign req_ch.ready  = req_ready;
   assign rsp_ch.status = rsp_status;

endmodule

// ----- src/bfc_ctrl.sv -----
module bfc_ctrl import bfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.capture      = 1'b0;
      cmd.cursor_clear = 1'b0;
      cmd.ord_load     = 1'b0;
      cmd.ord_inc      = 1'b0;
      cmd.ord_dec      = 1'b0;
      cmd.rd_sel       = RD_NONE;
      cmd.wr_sel       = WR_NONE;
      cmd.res_sel      = RES_NONE;
      cmd.out_load     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_fetch) begin
               cmd.rd_sel = RD_SCAN_FIRST;
               state_in   = S_SCAN;
            end else begin
               cmd.cursor_clear = 1'b1;
               if (sts.bad) begin
                  cmd.res_sel = RES_REJECT;
                  state_in    = S_RESP;
               end else begin
                  cmd.ord_load = 1'b1;
                  state_in     = S_OVL_RD;
               end
            end
         end
         S_OVL_RD: begin
            cmd.rd_sel = RD_CUR;
            state_in   = S_OVL_TEST;
         end
         S_OVL_TEST: begin
            // own order: anything free inside the block; above: a free ancestor
            if (sts.at_k ? sts.cur_occ : sts.cur_free) begin
               cmd.res_sel = RES_REJECT;
               state_in    = S_RESP;
            end else if (sts.at_top) begin
               state_in = S_OCC;
            end else begin
               cmd.ord_inc = 1'b1;
               state_in    = S_OVL_RD;
            end
         end
         S_OCC: begin
            // mark the path down to the block's own order as occupied
            cmd.wr_sel = WR_OCC_SET;
            if (sts.at_k) begin
               state_in = S_MRG_RD;
            end else begin
               cmd.ord_dec = 1'b1;
            end
         end
         S_MRG_RD: begin
            if (sts.at_top) begin
               state_in = S_SET;
            end else begin
               cmd.rd_sel = RD_BUDDY;
               state_in   = S_MRG_TEST;
            end
         end
         S_MRG_TEST: begin
            if (sts.buddy_free) begin
               cmd.wr_sel  = WR_BUDDY_CLR;
               cmd.ord_inc = 1'b1;
               state_in    = S_MRG_RD;
            end else begin
               state_in = S_SET;
            end
         end
         S_SET: begin
            cmd.wr_sel  = WR_FREE_SET;
            cmd.res_sel = RES_ACCEPT;
            state_in    = S_RESP;
         end
         S_SCAN: begin
            if (sts.hit) begin
               cmd.res_sel = RES_LISTED;
               state_in    = S_RESP;
            end else if (sts.row_last) begin
               cmd.res_sel      = RES_END;
               cmd.cursor_clear = 1'b1;
               state_in         = S_RESP;
            end else begin
               cmd.rd_sel = RD_SCAN_NEXT;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ----- src/bfc_datapath.sv -----
module bfc_datapath import bfc_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [ORDER_W-1:0] req_block_order,
   input  logic [ADDR_W-1:0]  req_block_addr,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output status_type         rsp_status,
   output logic [ORDER_W-1:0] rsp_out_order,
   output logic [ADDR_W-1:0]  rsp_out_addr,
   output logic               rsp_first_of_order
);

   localparam int SLOT_W = ADDR_BITS + 1;
   localparam int COL_W  = (SLOT_W - 1 < MAX_COL_W) ? SLOT_W - 1 : MAX_COL_W;
   localparam int ROW_W  = SLOT_W - COL_W;
   localparam int COLS   = 1 << COL_W;
   localparam int ROWS   = 1 << ROW_W;
   localparam int WORD_W = 2 * COLS;
   localparam int ORD_W  = $clog2(ADDR_BITS + 1);

   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [ROW_W-1:0]     row_type;
   typedef logic [COL_W-1:0]     col_type;
   typedef logic [COLS-1:0]      bits_type;
   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [ADDR_BITS-1:0] uaddr_type;
   typedef logic [ORD_W-1:0]     ord_type;

   // slots of order o start where the top o bits are ones
   function automatic slot_type slot_of(input ord_type o, input uaddr_type i);
      slot_of = ~({SLOT_W{1'b1}} >> o) | slot_type'(i);
   endfunction

   // row word: low half free bits, high half occupied-below bits
   word_type map_mem [ROWS];

   logic [FUNC_W-1:0]  func_ff;
   logic [ORDER_W-1:0] k_ff;
   logic [ADDR_W-1:0]  addr_ff;
   ord_type            ord_ff;
   slot_type           cursor_ff;
   ord_type            last_ord_ff;
   row_type            row_ff;
   row_type            clr_row_ff;
   word_type           rd_data_ff;

   status_type         res_status_ff;
   logic [ORDER_W-1:0] res_order_ff;
   logic [ADDR_W-1:0]  res_addr_ff;
   logic               res_first_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ORDER_W-1:0] rsp_order_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic               rsp_first_ff;

   uaddr_type uaddr;
   uaddr_type idx;
   slot_type  cur_slot;
   slot_type  buddy_slot;
   col_type   cur_col;
   col_type   buddy_col;
   row_type   cursor_row;
   col_type   cursor_col;

   row_type   rd_row;
   row_type   wr_row;
   logic      wr_en;
   word_type  wr_mask;
   word_type  wr_data;

   bits_type  scan_mask;
   bits_type  cand;
   col_type   hit_col;
   slot_type  found_slot;
   ord_type   found_ord;
   uaddr_type found_idx;
   uaddr_type found_addr;
   logic      found_first;
   uaddr_type merged_addr;

   assign uaddr      = uaddr_type'(addr_ff);
   assign idx        = uaddr >> ord_ff;
   assign cur_slot   = slot_of(ord_ff, idx);
   assign buddy_slot = slot_of(ord_ff, idx ^ uaddr_type'(1));
   assign cur_col    = cur_slot[COL_W-1:0];
   assign buddy_col  = buddy_slot[COL_W-1:0];
   assign cursor_row = cursor_ff[SLOT_W-1:COL_W];
   assign cursor_col = cursor_ff[COL_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_BUDDY:      rd_row = buddy_slot[SLOT_W-1:COL_W];
         RD_SCAN_FIRST: rd_row = cursor_row;
         RD_SCAN_NEXT:  rd_row = row_ff + row_type'(1);
         default:       rd_row = cur_slot[SLOT_W-1:COL_W];
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_row  = cur_slot[SLOT_W-1:COL_W];
      wr_mask = '0;
      wr_data = '0;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            wr_row  = clr_row_ff;
            wr_mask = '1;
         end
         WR_OCC_SET: begin
            wr_mask = (word_type'(1) << COLS) << cur_col;
            wr_data = '1;
         end
         WR_BUDDY_CLR: begin
            wr_row  = buddy_slot[SLOT_W-1:COL_W];
            wr_mask = word_type'(1) << buddy_col;
         end
         WR_FREE_SET: begin
            wr_mask = word_type'(1) << cur_col;
            wr_data = '1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[rd_row];
      if (wr_en) begin
         for (int b = 0; b < WORD_W; b++) begin
            if (wr_mask[b]) begin
               map_mem[wr_row][b] <= wr_data[b];
            end
         end
      end
   end

   // only the cursor's own row hides the blocks already listed
   assign scan_mask = (row_ff == cursor_row) ? ({COLS{1'b1}} << cursor_col) : '1;
   assign cand      = rd_data_ff[COLS-1:0] & scan_mask;

   always_comb begin
      hit_col = '0;
      for (int c = COLS - 1; c >= 0; c--) begin
         if (cand[c]) begin
            hit_col = col_type'(c);
         end
      end
   end

   assign found_slot = {row_ff, hit_col};

   // order is the run of leading ones in the slot number
   always_comb begin
      found_ord = '0;
      for (int b = 0; b < SLOT_W; b++) begin
         if (!found_slot[b]) begin
            found_ord = ord_type'(SLOT_W - 1 - b);
         end
      end
   end

   assign found_idx   = uaddr_type'(found_slot & (({SLOT_W{1'b1}} >> 1) >> found_ord));
   assign found_addr  = found_idx << found_ord;
   assign found_first = (cursor_ff == '0) || (found_ord != last_ord_ff);
   assign merged_addr = uaddr & ({ADDR_BITS{1'b1}} << ord_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         k_ff    <= req_block_order;
         addr_ff <= req_block_addr;
      end
      if (cmd.ord_load) begin
         ord_ff <= ord_type'(k_ff);
      end else if (cmd.ord_inc) begin
         ord_ff <= ord_ff + ord_type'(1);
      end else if (cmd.ord_dec) begin
         ord_ff <= ord_ff - ord_type'(1);
      end
      if (cmd.rd_sel == RD_SCAN_FIRST) begin
         row_ff <= cursor_row;
      end else if (cmd.rd_sel == RD_SCAN_NEXT) begin
         row_ff <= row_ff + row_type'(1);
      end
      case (cmd.res_sel)
         RES_REJECT: begin
            res_status_ff <= ST_REJECT;
            res_order_ff  <= '0;
            res_addr_ff   <= '0;
            res_first_ff  <= 1'b0;
         end
         RES_ACCEPT: begin
            res_status_ff <= ST_ACCEPT;
            res_order_ff  <= ORDER_W'(ord_ff);
            res_addr_ff   <= ADDR_W'(merged_addr);
            res_first_ff  <= 1'b0;
         end
         RES_LISTED: begin
            res_status_ff <= ST_LISTED;
            res_order_ff  <= ORDER_W'(found_ord);
            res_addr_ff   <= ADDR_W'(found_addr);
            res_first_ff  <= found_first;
         end
         RES_END: begin
            res_status_ff <= ST_END;
            res_order_ff  <= '0;
            res_addr_ff   <= '0;
            res_first_ff  <= 1'b0;
         end
         default: begin
         end
      endcase
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_order_ff  <= res_order_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_first_ff  <= res_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff   <= '0;
         cursor_ff    <= '0;
         last_ord_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_sel == WR_CLEAR) begin
            clr_row_ff <= clr_row_ff + row_type'(1);
         end
         if (cmd.cursor_clear) begin
            cursor_ff <= '0;
         end else if (cmd.res_sel == RES_LISTED) begin
            cursor_ff <= found_slot + slot_type'(1);
         end
         if (cmd.res_sel == RES_LISTED) begin
            last_ord_ff <= found_ord;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.is_fetch   = (func_ff == FUNC_FETCH);
      sts.bad        = (int'(k_ff) > ADDR_BITS) || ((addr_ff >> ADDR_BITS) != '0) ||
                       ((addr_ff & ~({ADDR_W{1'b1}} << k_ff)) != '0);
      sts.at_top     = (ord_ff == ord_type'(ADDR_BITS));
      sts.at_k       = (ord_ff == ord_type'(k_ff));
      sts.cur_occ    = rd_data_ff[{1'b1, cur_col}];
      sts.cur_free   = rd_data_ff[{1'b0, cur_col}];
      sts.buddy_free = rd_data_ff[{1'b0, buddy_col}];
      sts.hit        = |cand;
      sts.row_last   = (row_ff == '1);
      sts.clr_last   = (clr_row_ff == '1);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_order      = rsp_order_ff;
   assign rsp_out_addr       = rsp_addr_ff;
   assign rsp_first_of_order = rsp_first_ff;

endmodule

// ----- src/bfc_checker.sv -----
`include "buddy_free_block_coalescer_assert.svh"

module bfc_checker import bfc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ORDER_W-1:0]  rsp_out_order,
   input logic [ADDR_W-1:0]   rsp_out_addr,
   input logic                rsp_first_of_order
);

   `BFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_out_order) &&
      $stable(rsp_out_addr) && $stable(rsp_first_of_order),
      "stalled result item changed")

   `BFC_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready,
      "item taken during bitmap clearing")

   `BFC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready,
      "second item taken while one is at work")

   `BFC_ASSERT_NOW(a_empty_fields, clock, reset,
      rsp_valid && (rsp_status == ST_REJECT || rsp_status == ST_END),
      rsp_out_order == '0 && rsp_out_addr == '0 && !rsp_first_of_order,
      "reject or end item carries block fields")

endmodule

bind buddy_free_block_coalescer bfc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_out_order      (rsp_ch.out_order),
   .rsp_out_addr       (rsp_ch.out_addr),
   .rsp_first_of_order (rsp_ch.first_of_order)
);

// ----- verif/buddy_free_block_coalescer_test.sv -----
module buddy_free_block_coalescer_test;
   import bfc_pkg::*;

   localparam int TOP_ORDER   = ADDR_BITS_DEFAULT;
   localparam int UNITS       = 1 << TOP_ORDER;
   localparam int RANDOM_STOP = 880;

   typedef struct packed {
      status_type          status;
      logic [ORDER_W-1:0]  blk_order;
      logic [ADDR_W-1:0]   blk_addr;
      logic                first_seen;
   } reply_type;

   logic clock;
   logic reset;

   bfc_req_if req_ch ();
   bfc_rsp_if rsp_ch ();

   buddy_free_block_coalescer #(.ADDR_BITS(ADDR_BITS_DEFAULT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state: one free bit per aligned block of every order
   bit     free_map [0:TOP_ORDER][0:UNITS-1];
   int     cursor_order;
   int     cursor_index;
   int     last_order;

   reply_type due_replies [$];
   reply_type next_due;
   int        errors;
   int        items_sent;
   bit        steady;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #4000000;
      $display("FAIL buddy_free_block_coalescer");
      $finish;
   end

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
   endtask

   // true when no free block of any order overlaps the given block
   function automatic bit block_clear(int ord, int addr);
      int j;
      int i;
      for (j = 0; j <= TOP_ORDER; j++) begin
         if (j >= ord) begin
            if (free_map[j][addr >> j]) return 1'b0;
         end else begin
            for (i = 0; i < (1 << (ord - j)); i++)
               if (free_map[j][(addr >> j) + i]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic reply_type coalesce_and_list(logic fn, logic [ORDER_W-1:0] ord,
                                                   logic [ADDR_W-1:0] addr);
      reply_type r;
      int        k;
      int        idx;
      int        o;
      int        i;
      int        n;
      bit        found;
      r = '0;
      if (fn == FUNC_INSERT) begin
         cursor_order = 0;
         cursor_index = 0;
         if (ord > TOP_ORDER) begin
            r.status = ST_REJECT;
         end else if ((int'(addr) % (1 << ord)) != 0 ||
                      !block_clear(int'(ord), int'(addr))) begin
            r.status = ST_REJECT;
         end else begin
            k = int'(ord);
            idx = int'(addr) >> k;
            // absorb the buddy while it is free, climbing one order each time
            while (k < TOP_ORDER && free_map[k][idx ^ 1]) begin
               free_map[k][idx ^ 1] = 1'b0;
               idx = idx >> 1;
               k++;
            end
            free_map[k][idx] = 1'b1;
            r.status    = ST_ACCEPT;
            r.blk_order = ORDER_W'(k);
            r.blk_addr  = ADDR_W'(idx << k);
         end
         return r;
      end
      found = 1'b0;
      for (o = cursor_order; o <= TOP_ORDER && !found; o++) begin
         n = 1 << (TOP_ORDER - o);
         for (i = (o == cursor_order) ? cursor_index : 0; i < n && !found; i++) begin
            if (free_map[o][i]) begin
               found        = 1'b1;
               r.status     = ST_LISTED;
               r.blk_order  = ORDER_W'(o);
               r.blk_addr   = ADDR_W'(i << o);
               r.first_seen = (cursor_order == 0 && cursor_index == 0) || o != last_order;
               last_order   = o;
               if (i + 1 >= n) begin
                  cursor_order = o + 1;
                  cursor_index = 0;
               end else begin
                  cursor_order = o;
                  cursor_index = i + 1;
               end
            end
         end
      end
      if (!found) begin
         r.status     = ST_END;
         cursor_order = 0;
         cursor_index = 0;
      end
      return r;
   endfunction

   task automatic send_item(logic fn, logic [ORDER_W-1:0] ord, logic [ADDR_W-1:0] addr);
      int gap;
      gap = steady ? 0 : int'($urandom_range(0, 6));
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.func        <= fn;
      req_ch.block_order <= ord;
      req_ch.block_addr  <= addr;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      due_replies.push_back(coalesce_and_list(fn, ord, addr));
      items_sent++;
   endtask

   task automatic wait_for_replies;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed;
      send_item(FUNC_FETCH, 0, 0);
      send_item(FUNC_INSERT, 0, 1023);
      send_item(FUNC_INSERT, 0, 1022);
      send_item(FUNC_INSERT, 1, 1020);
      send_item(FUNC_INSERT, 0, 1021);
      send_item(FUNC_INSERT, 3, 1016);
      send_item(FUNC_INSERT, 15, 0);
      send_item(FUNC_INSERT, 10, 0);
      send_item(FUNC_INSERT, 2, 2);
      send_item(FUNC_INSERT, 0, 0);
      send_item(FUNC_INSERT, 4, 16);
      send_item(FUNC_INSERT, 5, 32);
      send_item(FUNC_FETCH, 15, 1023);
      send_item(FUNC_FETCH, 0, 0);
      send_item(FUNC_FETCH, 0, 0);
      // insert in mid-listing: the next fetch starts over
      send_item(FUNC_INSERT, 1, 2);
      repeat (6) send_item(FUNC_FETCH, 0, 0);
      send_item(FUNC_FETCH, 0, 0);
      // restart right after an order-0 listing
      send_item(FUNC_INSERT, 0, 0);
      send_item(FUNC_FETCH, 0, 0);
      wait_for_replies;
   endtask

   task automatic test_random_fill;
      int round;
      int pick;
      int o;
      int a;
      int tries;
      int listed;
      int run;
      int j;
      int i;
      round = 0;
      while (items_sent < RANDOM_STOP) begin
         steady = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(4, 14)) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 7) begin
               o = ($urandom_range(0, 9) == 0) ? int'($urandom_range(2, 5))
                                                : int'($urandom_range(0, 1));
               tries = 0;
               // look for a block that is not yet free
               do begin
                  a = int'($urandom_range(0, (1 << (TOP_ORDER - o)) - 1)) << o;
                  tries++;
               end while (tries < 16 && !block_clear(o, a));
               send_item(FUNC_INSERT, ORDER_W'(o), ADDR_W'(a));
            end else if (pick < 9) begin
               send_item(FUNC_INSERT, ORDER_W'($urandom_range(0, 15)),
                         ADDR_W'($urandom_range(0, 1023)));
            end else begin
               send_item(FUNC_FETCH, ORDER_W'($urandom_range(0, 15)),
                         ADDR_W'($urandom_range(0, 1023)));
            end
         end
         listed = 0;
         for (j = 0; j <= TOP_ORDER; j++)
            for (i = 0; i < UNITS; i++)
               listed += int'(free_map[j][i]);
         // walk the whole list past its end when it is short, else a prefix
         if (listed <= 40 || (listed <= 120 && $urandom_range(0, 5) == 0))
            run = listed + 1 + int'($urandom_range(0, 2));
         else
            run = int'($urandom_range(1, 24));
         repeat (run) send_item(FUNC_FETCH, ORDER_W'($urandom_range(0, 15)),
                                ADDR_W'($urandom_range(0, 1023)));
         round++;
         if (round % 9 == 0) wait_for_replies;
      end
      steady = 1'b0;
   endtask

   task automatic test_fill_to_top;
      int addr;
      int o;
      addr = 0;
      // hand back the largest clear aligned block at each hole
      while (addr < UNITS) begin
         o = TOP_ORDER;
         while (o > 0 && ((addr % (1 << o)) != 0 || !block_clear(o, addr))) o--;
         if (block_clear(o, addr)) begin
            send_item(FUNC_INSERT, ORDER_W'(o), ADDR_W'(addr));
            addr += 1 << o;
         end else begin
            addr++;
         end
      end
      repeat (3) send_item(FUNC_FETCH, 0, 0);
      send_item(FUNC_INSERT, 10, 0);
      send_item(FUNC_INSERT, 0, 1023);
      send_item(FUNC_FETCH, 0, 0);
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (due_replies.size() == 0) begin
            report_mismatch("reply with no item outstanding");
         end else begin
            next_due = due_replies.pop_front();
            if (rsp_ch.status !== next_due.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_ch.status, next_due.status));
            if (rsp_ch.out_order !== next_due.blk_order)
               report_mismatch($sformatf("out_order %0d, want %0d",
                                         rsp_ch.out_order, next_due.blk_order));
            if (rsp_ch.out_addr !== next_due.blk_addr)
               report_mismatch($sformatf("out_addr %0d, want %0d",
                                         rsp_ch.out_addr, next_due.blk_addr));
            if (rsp_ch.first_of_order !== next_due.first_seen)
               report_mismatch($sformatf("first_of_order %0d, want %0d",
                                         rsp_ch.first_of_order, next_due.first_seen));
         end
      end
   end

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = steady ? 0 : int'($urandom_range(0, 6));
         if (stall > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (reset !== 1'b0 || rsp_ch.valid !== 1'b1 || rsp_ch.ready !== 1'b1)
            @(posedge clock);
      end
   end

   initial begin
      errors             = 0;
      items_sent         = 0;
      steady             = 1'b0;
      cursor_order       = 0;
      cursor_index       = 0;
      last_order         = 0;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_INSERT;
      req_ch.block_order = '0;
      req_ch.block_addr  = '0;
      reset              = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed;
      test_random_fill;
      test_fill_to_top;
      wait_for_replies;
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("PASS buddy_free_block_coalescer");
      else
         $display("FAIL buddy_free_block_coalescer");
      $finish;
   end

endmodule
